[design/cma_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_pkg
// Shared types and constants for the centered moving average block.
// ----------------------------------------------------------------------------
package cma_pkg;

   localparam int MAX_WINDOW_DEFAULT  = 63;
   localparam int SAMPLE_BITS_DEFAULT = 32;
   localparam int FIELD_BITS          = 32;
   localparam int CFG_W               = 6;
   localparam logic [CFG_W-1:0] CFG_RESET = 6'd5;
   localparam int OFF_W               = 8;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] sample;
      logic                         end_of_input;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] smoothed;
      logic                         end_of_run;
      logic                         end_of_sequence;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SUM,
      ST_DRAIN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SRC_CUR,
      SRC_FIRST,
      SRC_MEM
   } src_type;

endpackage

[design/centered_moving_average.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average
// Centered moving average over one sequence with edge replication.
// ----------------------------------------------------------------------------
// One item at a time. Each result sums a window of 2h+1 taps, h = floor(len/2),
// into a sum of SUM_W = SAMPLE_BITS + clog2(MAX_WINDOW+1) + 1 bits (39 by
// default): one window read per cycle from the single-port sample memory, then a
// radix-2 restoring divider. The final item of a sequence gives min(samples,h+1)
// results back to back, oldest first.
// A new item is taken as soon as the last result is in the output register.
module centered_moving_average #(
   parameter int MAX_WINDOW  = cma_pkg::MAX_WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = cma_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  cma_pkg::req_type          req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output cma_pkg::rsp_type          rsp_data,
   input  logic                      csr_write_enable,
   input  logic [cma_pkg::CFG_W-1:0] csr_write_data
);

   localparam int DEPTH  = MAX_WINDOW + 1;
   localparam int PTR_W  = $clog2(DEPTH);
   localparam int SEEN_W = $clog2(DEPTH + 1);
   localparam int AW     = PTR_W + 2;
   localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_WINDOW + 1) + 1;
   localparam int QW     = SUM_W + 1;
   localparam int CNT_W  = $clog2(SUM_W);
   localparam int SW     = (SAMPLE_BITS > cma_pkg::FIELD_BITS) ? SAMPLE_BITS
                                                               : cma_pkg::FIELD_BITS;
   localparam int CW     = cma_pkg::CFG_W;
   localparam int HW     = CW - 1;
   localparam int OW     = cma_pkg::OFF_W;
   localparam logic signed [QW-1:0] Q_HI =
      {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
   localparam logic signed [QW-1:0] Q_LO = ~Q_HI;

   cma_pkg::state_type state_ff, state_in;
   cma_pkg::src_type   p_src_ff, p_src_in, src;

   logic [CW-1:0]                win_len_ff, win_len_in;
   logic [CW-1:0]                len_ff, len_in;
   logic [HW-1:0]                h_ff, h_in;
   logic [HW-1:0]                d_ff, d_in;
   logic [CW-1:0]                j_ff, j_in;
   logic                         last_ff, last_in;
   logic signed [SAMPLE_BITS-1:0] x_ff, x_in;
   logic signed [SAMPLE_BITS-1:0] first_ff, first_in;
   logic [PTR_W-1:0]             wp_ff, wp_in;
   logic [PTR_W-1:0]             cur_ff, cur_in;
   logic [SEEN_W-1:0]            seen_ff, seen_in;
   logic                         p_vld_ff, p_vld_in;
   logic signed [SAMPLE_BITS-1:0] rd_data_ff;
   logic signed [SUM_W-1:0]      sum_ff, sum_in;
   logic [SUM_W-1:0]             dq_ff, dq_in;
   logic [CW-1:0]                rem_ff, rem_in;
   logic                         neg_ff, neg_in;
   logic [CNT_W-1:0]             cnt_ff, cnt_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   cma_pkg::rsp_type             rsp_ff, rsp_in;

   logic signed [SAMPLE_BITS-1:0] mem [DEPTH];
   logic                         mem_we, mem_re;
   logic [PTR_W-1:0]             rd_addr;

   logic [SW-1:0]                in_ext;
   logic signed [SAMPLE_BITS-1:0] x_new;
   logic [CW-1:0]                len_eff;
   logic [HW-1:0]                h_eff;
   logic [SEEN_W-1:0]            seen_new;
   logic signed [OW-1:0]         off;
   logic [AW-1:0]                addr_sum;
   logic signed [SAMPLE_BITS-1:0] acc_val;
   logic [CW:0]                  div_t;
   logic signed [QW-1:0]         q_full;
   logic signed [SAMPLE_BITS-1:0] q_sat;
   logic [SW-1:0]                q_ext;
   logic                         out_free;

   always_comb begin
      in_ext   = SW'($unsigned(req_data.sample));
      x_new    = $signed(in_ext[SAMPLE_BITS-1:0]);
      if (win_len_ff == '0) begin
         len_eff = CW'(1);
      end else if (int'(win_len_ff) > MAX_WINDOW) begin
         len_eff = CW'(MAX_WINDOW);
      end else begin
         len_eff = win_len_ff;
      end
      h_eff    = len_eff[CW-1:1];
      seen_new = (int'(seen_ff) < DEPTH) ? seen_ff + SEEN_W'(1) : seen_ff;

      off      = $signed(OW'(d_ff) - OW'(h_ff) + OW'(j_ff));
      addr_sum = AW'(cur_ff) + AW'(DEPTH) - AW'(off[OW-2:0]);
      if (addr_sum >= AW'(DEPTH)) begin
         addr_sum = addr_sum - AW'(DEPTH);
      end
      rd_addr  = addr_sum[PTR_W-1:0];
      if (off < 0) begin
         src = cma_pkg::SRC_CUR;
      end else if (int'(off) >= int'(seen_ff)) begin
         src = cma_pkg::SRC_FIRST;
      end else begin
         src = cma_pkg::SRC_MEM;
      end

      case (p_src_ff)
         cma_pkg::SRC_CUR:   acc_val = x_ff;
         cma_pkg::SRC_FIRST: acc_val = first_ff;
         default:            acc_val = rd_data_ff;
      endcase

      div_t = {rem_ff, dq_ff[SUM_W-1]};

      q_full = neg_ff ? -$signed({1'b0, dq_ff}) : $signed({1'b0, dq_ff});
      if (q_full > Q_HI) begin
         q_sat = Q_HI[SAMPLE_BITS-1:0];
      end else if (q_full < Q_LO) begin
         q_sat = Q_LO[SAMPLE_BITS-1:0];
      end else begin
         q_sat = q_full[SAMPLE_BITS-1:0];
      end
      q_ext = SW'(q_sat);
   end

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      p_src_in     = p_src_ff;
      win_len_in   = csr_write_enable ? csr_write_data : win_len_ff;
      len_in       = len_ff;
      h_in         = h_ff;
      d_in         = d_ff;
      j_in         = j_ff;
      last_in      = last_ff;
      x_in         = x_ff;
      first_in     = first_ff;
      wp_in        = wp_ff;
      cur_in       = cur_ff;
      seen_in      = seen_ff;
      p_vld_in     = 1'b0;
      sum_in       = p_vld_ff ? sum_ff + SUM_W'(acc_val) : sum_ff;
      dq_in        = dq_ff;
      rem_in       = rem_ff;
      neg_in       = neg_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      mem_we       = 1'b0;
      mem_re       = 1'b0;
      req_ready    = 1'b0;

      case (state_ff)
         cma_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               mem_we   = 1'b1;
               x_in     = x_new;
               if (seen_ff == '0) begin
                  first_in = x_new;
               end
               cur_in   = wp_ff;
               wp_in    = (wp_ff == PTR_W'(DEPTH - 1)) ? '0 : wp_ff + PTR_W'(1);
               seen_in  = seen_new;
               len_in   = len_eff;
               h_in     = h_eff;
               last_in  = req_data.end_of_input;
               j_in     = '0;
               sum_in   = '0;
               if (req_data.end_of_input) begin
                  d_in     = (int'(seen_new) - 1 < int'(h_eff)) ? HW'(seen_new - SEEN_W'(1))
                                                              : h_eff;
                  state_in = cma_pkg::ST_SUM;
               end else if (int'(seen_new) > int'(h_eff)) begin
                  d_in     = h_eff;
                  state_in = cma_pkg::ST_SUM;
               end
            end
         end
         cma_pkg::ST_SUM: begin
            p_vld_in = 1'b1;
            p_src_in = src;
            mem_re   = (src == cma_pkg::SRC_MEM);
            j_in     = j_ff + CW'(1);
            if (j_ff == {h_ff, 1'b0}) begin
               state_in = cma_pkg::ST_DRAIN;
            end
         end
         cma_pkg::ST_DRAIN: begin
            state_in = cma_pkg::ST_DIV_LOAD;
         end
         cma_pkg::ST_DIV_LOAD: begin
            neg_in   = sum_ff < 0;
            dq_in    = (sum_ff < 0) ? $unsigned(-sum_ff) : $unsigned(sum_ff);
            rem_in   = '0;
            cnt_in   = '0;
            state_in = cma_pkg::ST_DIV;
         end
         cma_pkg::ST_DIV: begin
            if (div_t >= {1'b0, len_ff}) begin
               rem_in = CW'(div_t - {1'b0, len_ff});
               dq_in  = {dq_ff[SUM_W-2:0], 1'b1};
            end else begin
               rem_in = div_t[CW-1:0];
               dq_in  = {dq_ff[SUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(SUM_W - 1)) begin
               state_in = cma_pkg::ST_OUT;
            end
         end
         cma_pkg::ST_OUT: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_in.smoothed        = $signed(q_ext[cma_pkg::FIELD_BITS-1:0]);
               rsp_in.end_of_run      = !last_ff || (d_ff == '0);
               rsp_in.end_of_sequence = last_ff && (d_ff == '0);
               if (!last_ff || d_ff == '0) begin
                  if (last_ff) begin
                     seen_in = '0;
                     wp_in   = '0;
                  end
                  state_in = cma_pkg::ST_IDLE;
               end else begin
                  d_in     = d_ff - HW'(1);
                  j_in     = '0;
                  sum_in   = '0;
                  state_in = cma_pkg::ST_SUM;
               end
            end
         end
         default: begin
            state_in = cma_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cma_pkg::ST_IDLE;
         win_len_ff   <= cma_pkg::CFG_RESET;
         wp_ff        <= '0;
         seen_ff      <= '0;
         first_ff     <= '0;
         p_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         win_len_ff   <= win_len_in;
         wp_ff        <= wp_in;
         seen_ff      <= seen_in;
         first_ff     <= first_in;
         p_vld_ff     <= p_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_src_ff <= p_src_in;
      len_ff   <= len_in;
      h_ff     <= h_in;
      d_ff     <= d_in;
      j_ff     <= j_in;
      last_ff  <= last_in;
      x_ff     <= x_in;
      cur_ff   <= cur_in;
      sum_ff   <= sum_in;
      dq_ff    <= dq_in;
      rem_ff   <= rem_in;
      neg_ff   <= neg_in;
      cnt_ff   <= cnt_in;
      rsp_ff   <= rsp_in;
   end

   // sample memory: write on item accept, one read per window tap taken from memory
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff] <= x_new;
      end
      if (mem_re) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[design/cma_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cma_checker
// Port-level checks for the centered moving average block.
// ----------------------------------------------------------------------------
module cma_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input cma_pkg::req_type          req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input cma_pkg::rsp_type          rsp_data,
   input logic                      csr_write_enable,
   input logic [cma_pkg::CFG_W-1:0] csr_write_data
);

   // no result comes out of reset
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // the last item of a sequence always gives a result, so the input closes
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.end_of_input |=> !req_ready)
      else $error("item taken right after the last item of a sequence");

   // no result can be produced in the cycle after an item with nothing pending
   a_no_early_result: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready |=> !rsp_valid)
      else $error("result appeared one cycle after accept");

   a_eos_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.end_of_sequence |-> rsp_data.end_of_run)
      else $error("end of sequence without end of run");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind centered_moving_average cma_checker u_cma_checker (.*);
